// ===== hw/rtl/pcfp_pkg.sv =====
// Shared types and constants for the panel command frame parser.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package pcfp_pkg;

	localparam int unsigned WIN_DEPTH = 9;

	localparam logic [7:0] BYTE_SYNC0  = 8'h55;
	localparam logic [7:0] BYTE_SYNC1  = 8'hAA;
	localparam logic [7:0] BYTE_CR     = 8'h0D;
	localparam logic [7:0] BYTE_LF     = 8'h0A;
	localparam logic [7:0] BYTE_STATUS = 8'hFF;

	localparam logic [7:0] CMD_COLOR   = 8'h04;
	localparam logic [7:0] CMD_FAN     = 8'h05;
	localparam logic [7:0] CMD_COLOR2  = 8'h06;
	localparam logic [7:0] CMD_QSTRIP  = 8'h07;
	localparam logic [7:0] CMD_QFAN    = 8'h08;

	localparam logic [1:0] EV_COLOR    = 2'd0;
	localparam logic [1:0] EV_FAN      = 2'd1;
	localparam logic [1:0] EV_QSTRIP   = 2'd2;
	localparam logic [1:0] EV_QFAN     = 2'd3;

	localparam logic [15:0] FAN_LIMIT_RST = 16'd1000;

	// register index of the fan speed limit
	localparam logic REG_FAN_LIMIT = 1'b0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_HOLD
	} pcfp_state_t;

	typedef struct packed {
		logic append;
		logic step;
		logic load_out;
	} pcfp_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic ev_got;
	} pcfp_status_t;

endpackage

// ===== hw/rtl/pcfp_ctrl.sv =====
// Sequencer for the frame parser: append, scan steps, result hand-off.
// Depends on pcfp_pkg.
`timescale 1ns / 1ps

module pcfp_ctrl import pcfp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	output logic         out_valid,
	input  logic         out_stall,
	input  pcfp_status_t status,
	output pcfp_cmd_t    cmd
);

	pcfp_state_t state_q, state_d;
	logic        out_valid_q;
	logic        out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (status.scan_done) begin
					if (status.ev_got && !out_free) state_d = ST_HOLD;
					else state_d = ST_IDLE;
				end
			end
			ST_HOLD: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.append = in_valid;
			end
			ST_SCAN: begin
				cmd.step     = !status.scan_done;
				cmd.load_out = status.scan_done && status.ev_got && out_free;
			end
			ST_HOLD: begin
				cmd.load_out = out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== hw/rtl/pcfp_dp.sv =====
// Datapath: nine-byte receive window, one frame-match step per cycle,
// event capture and output register. Depends on pcfp_pkg.
`timescale 1ns / 1ps

module pcfp_dp import pcfp_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  pcfp_cmd_t     cmd,
	output pcfp_status_t  status,
	input  logic [7:0]    rx_byte,
	input  logic [15:0]   fan_limit,
	output logic [1:0]    event_kind,
	output logic [1:0]    strip_select,
	output logic [1:0]    strip_tag,
	output logic [7:0]    red,
	output logic [7:0]    green,
	output logic [7:0]    blue,
	output logic [15:0]   fan_speed,
	output logic          fan_byte_swapped,
	output logic          fan_clamped
);

	localparam logic [3:0] DEPTH_C = 4'(WIN_DEPTH);

	logic [7:0]  win_q [WIN_DEPTH];
	logic [3:0]  cnt_q;
	logic        got_q;

	// front-of-window decode
	logic [3:0]  adv;
	logic        brk;
	logic        hit;
	logic [1:0]  c_kind, c_sel, c_tag;
	logic [7:0]  c_r, c_g, c_b;
	logic [15:0] c_spd;
	logic        c_sw, c_cl;

	// captured event
	logic [1:0]  ev_kind_q, ev_sel_q, ev_tag_q;
	logic [7:0]  ev_r_q, ev_g_q, ev_b_q;
	logic [15:0] ev_spd_q;
	logic        ev_sw_q, ev_cl_q;

	logic [7:0]  o_r_q, o_g_q, o_b_q;
	logic [1:0]  o_kind_q, o_sel_q, o_tag_q;
	logic [15:0] o_spd_q;
	logic        o_sw_q, o_cl_q;

	logic [15:0] be, le;
	logic [7:0]  win_sh [WIN_DEPTH];
	logic [3:0]  sh_amt;

	function automatic logic tail_at(input logic [7:0] a, input logic [7:0] b);
		return (a == BYTE_CR) && (b == BYTE_LF);
	endfunction

	function automatic logic [1:0] sel_of(input logic [7:0] id);
		return (id <= 8'd1) ? 2'd1 : 2'd2;
	endfunction

	function automatic logic [1:0] tag_of(input logic [7:0] id);
		return (id == 8'd0) ? 2'd1 : id[1:0];
	endfunction

	assign be = {win_q[3], win_q[4]};
	assign le = {win_q[4], win_q[3]};

	always_comb begin
		adv    = 4'd1;
		brk    = 1'b0;
		hit    = 1'b0;
		c_kind = EV_COLOR;
		c_sel  = '0;
		c_tag  = '0;
		c_r    = '0;
		c_g    = '0;
		c_b    = '0;
		c_spd  = '0;
		c_sw   = 1'b0;
		c_cl   = 1'b0;
		if (win_q[0] != BYTE_SYNC0 || win_q[1] != BYTE_SYNC1) begin
			// status run: any byte then FF FF FF
			if (cnt_q >= 4'd4 && win_q[1] == BYTE_STATUS && win_q[2] == BYTE_STATUS &&
					win_q[3] == BYTE_STATUS)
				adv = 4'd4;
		end else begin
			case (win_q[2])
				CMD_COLOR: begin
					if (cnt_q < 4'd8) begin
						brk = 1'b1;
					end else if (cnt_q == DEPTH_C && tail_at(win_q[7], win_q[8])) begin
						adv    = 4'd9;
						hit    = (win_q[3] <= 8'd3);
						c_kind = EV_COLOR;
						c_sel  = sel_of(win_q[3]);
						c_tag  = tag_of(win_q[3]);
						c_r    = win_q[4];
						c_g    = win_q[5];
						c_b    = win_q[6];
					end else if (tail_at(win_q[6], win_q[7])) begin
						adv    = 4'd8;
						hit    = 1'b1;
						c_kind = EV_COLOR;
						c_sel  = 2'd1;
						c_tag  = 2'd1;
						c_r    = win_q[3];
						c_g    = win_q[4];
						c_b    = win_q[5];
					end else if (cnt_q < DEPTH_C && win_q[7] == BYTE_CR) begin
						// could still be the nine-byte form
						brk = 1'b1;
					end
				end
				CMD_COLOR2: begin
					if (cnt_q < 4'd8) begin
						brk = 1'b1;
					end else if (tail_at(win_q[6], win_q[7])) begin
						adv    = 4'd8;
						hit    = 1'b1;
						c_kind = EV_COLOR;
						c_sel  = 2'd2;
						c_tag  = 2'd2;
						c_r    = win_q[3];
						c_g    = win_q[4];
						c_b    = win_q[5];
					end
				end
				CMD_FAN: begin
					if (cnt_q < 4'd7) begin
						brk = 1'b1;
					end else if (tail_at(win_q[5], win_q[6]) ||
							(cnt_q == DEPTH_C && tail_at(win_q[7], win_q[8]))) begin
						adv    = tail_at(win_q[5], win_q[6]) ? 4'd7 : 4'd9;
						hit    = 1'b1;
						c_kind = EV_FAN;
						if (be <= fan_limit) begin
							c_spd = be;
						end else if (le <= fan_limit) begin
							c_spd = le;
							c_sw  = 1'b1;
						end else begin
							c_spd = fan_limit;
							c_cl  = 1'b1;
						end
					end
				end
				CMD_QSTRIP: begin
					if (cnt_q < 4'd6) begin
						brk = 1'b1;
					end else if (tail_at(win_q[4], win_q[5])) begin
						adv    = 4'd6;
						hit    = (win_q[3] <= 8'd3);
						c_kind = EV_QSTRIP;
						c_sel  = sel_of(win_q[3]);
						c_tag  = tag_of(win_q[3]);
					end
				end
				CMD_QFAN: begin
					if (cnt_q < 4'd5) begin
						brk = 1'b1;
					end else if (tail_at(win_q[3], win_q[4])) begin
						adv    = 4'd5;
						hit    = 1'b1;
						c_kind = EV_QFAN;
					end
				end
				default: adv = 4'd1;
			endcase
		end
	end

	assign status.scan_done = (cnt_q < 4'd3) || brk;
	assign status.ev_got    = got_q;

	// append into a full window drops the oldest byte first
	assign sh_amt = cmd.step ? adv : 4'd1;

	always_comb begin
		logic [4:0] src;
		for (int k = 0; k < WIN_DEPTH; k++) begin
			src = 5'(k) + {1'b0, sh_amt};
			if (src < 5'(WIN_DEPTH)) win_sh[k] = win_q[src[3:0]];
			else win_sh[k] = win_q[k];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			win_q <= win_sh;
		end else if (cmd.append) begin
			if (cnt_q == DEPTH_C) begin
				for (int k = 0; k < WIN_DEPTH - 1; k++) win_q[k] <= win_sh[k];
				win_q[WIN_DEPTH - 1] <= rx_byte;
			end else begin
				win_q[cnt_q] <= rx_byte;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			got_q <= 1'b0;
		end else if (cmd.append) begin
			if (cnt_q != DEPTH_C) cnt_q <= cnt_q + 4'd1;
			got_q <= 1'b0;
		end else if (cmd.step) begin
			cnt_q <= cnt_q - adv;
			if (hit) got_q <= 1'b1;
		end
	end

	// only the first event of a rescan is kept
	always_ff @(posedge clk) begin
		if (cmd.step && hit && !got_q) begin
			ev_kind_q <= c_kind;
			ev_sel_q  <= c_sel;
			ev_tag_q  <= c_tag;
			ev_r_q    <= c_r;
			ev_g_q    <= c_g;
			ev_b_q    <= c_b;
			ev_spd_q  <= c_spd;
			ev_sw_q   <= c_sw;
			ev_cl_q   <= c_cl;
		end
		if (cmd.load_out) begin
			o_kind_q <= ev_kind_q;
			o_sel_q  <= ev_sel_q;
			o_tag_q  <= ev_tag_q;
			o_r_q    <= ev_r_q;
			o_g_q    <= ev_g_q;
			o_b_q    <= ev_b_q;
			o_spd_q  <= ev_spd_q;
			o_sw_q   <= ev_sw_q;
			o_cl_q   <= ev_cl_q;
		end
	end

	assign event_kind       = o_kind_q;
	assign strip_select     = o_sel_q;
	assign strip_tag        = o_tag_q;
	assign red              = o_r_q;
	assign green            = o_g_q;
	assign blue             = o_b_q;
	assign fan_speed        = o_spd_q;
	assign fan_byte_swapped = o_sw_q;
	assign fan_clamped      = o_cl_q;

endmodule

// ===== hw/rtl/panel_command_frame_parser.sv =====
//  channel | handshake            | payload
//  in      | in_valid / in_stall  | rx_byte
//  out     | out_valid / out_stall| event_kind .. fan_clamped
//  cfg     | APB write/read       | fan_speed_limit at 0x0
//
// One byte is taken in the idle state; the window rescan then runs one frame
// match per cycle: append, up to 7 match steps, final check. A finished event
// sits in the output register while the next byte is taken; if it is still
// stalled when the next event is ready, the parser holds there.
// Reset empties the window and loads the fan limit with 1000.
//
// Top level: APB register, controller and datapath. Depends on pcfp_pkg,
// pcfp_ctrl and pcfp_dp.
`timescale 1ns / 1ps

module panel_command_frame_parser import pcfp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  event_kind,
	output logic [1:0]  strip_select,
	output logic [1:0]  strip_tag,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [15:0] fan_speed,
	output logic        fan_byte_swapped,
	output logic        fan_clamped,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [15:0]  fan_limit_q;
	pcfp_cmd_t    cmd;
	pcfp_status_t status;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fan_limit_q <= FAN_LIMIT_RST;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_FAN_LIMIT) begin
			fan_limit_q <= pwdata[15:0];
		end
	end

	assign prdata = (paddr[2] == REG_FAN_LIMIT) ? {16'd0, fan_limit_q} : 32'd0;

	pcfp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	pcfp_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.rx_byte          (rx_byte),
		.fan_limit        (fan_limit_q),
		.event_kind       (event_kind),
		.strip_select     (strip_select),
		.strip_tag        (strip_tag),
		.red              (red),
		.green            (green),
		.blue             (blue),
		.fan_speed        (fan_speed),
		.fan_byte_swapped (fan_byte_swapped),
		.fan_clamped      (fan_clamped)
	);

endmodule

// ===== hw/rtl/pcfp_checker.sv =====
// Port-level checks for the frame parser, bound to the top level.
// Depends on pcfp_pkg and panel_command_frame_parser.
`timescale 1ns / 1ps

module pcfp_checker import pcfp_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  event_kind,
	input logic [1:0]  strip_select,
	input logic [1:0]  strip_tag,
	input logic [7:0]  red,
	input logic [7:0]  green,
	input logic [7:0]  blue,
	input logic [15:0] fan_speed,
	input logic        fan_byte_swapped,
	input logic        fan_clamped
);

	// a stalled transfer stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped under stall");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(event_kind) && $stable(fan_speed) &&
			$stable(red) && $stable(green) && $stable(blue) && $stable(strip_tag))
		else $error("payload changed under stall");

	a_fan_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind != EV_FAN |->
			fan_speed == 16'd0 && !fan_byte_swapped && !fan_clamped)
		else $error("fan fields set on a non-fan event");

	a_fan_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == EV_FAN |->
			!(fan_byte_swapped && fan_clamped) && strip_select == 2'd0)
		else $error("bad fan event flags");

	a_strip_sel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_kind == EV_COLOR || event_kind == EV_QSTRIP) |->
			(strip_select == 2'd1 || strip_select == 2'd2) && strip_tag != 2'd0)
		else $error("bad strip select or tag");

endmodule

bind panel_command_frame_parser pcfp_checker u_pcfp_checker (.*);
